// ===== hw/rtl/chained_hash_cache_average_evict_unit_macros.svh =====
// Assertion macros for the chained hash cache unit.
// Used by the top level only; no other dependencies.
`ifndef CHAINED_HASH_CACHE_AVERAGE_EVICT_UNIT_MACROS_SVH
`define CHAINED_HASH_CACHE_AVERAGE_EVICT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CHCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chce assertion failed");
// Next-cycle implication
`define CHCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chce assertion failed");
`else
`define CHCE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CHCE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/chce_pkg.sv =====
// Shared constants and types for the chained hash cache unit.
// No dependencies.
package chce_pkg;

   localparam int POOL_ENTRIES_DEF = 1024;
   localparam int CHAIN_SLOTS_DEF  = 1031;
   localparam int KEY_BITS_DEF     = 64;
   localparam int TAG_BITS_DEF     = 16;

   localparam int BUCKET_W    = 11;
   localparam int SLOT_OUT_W  = 10;
   localparam int COUNT_OUT_W = 11;
   localparam int HITS_W      = 32;
   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   typedef enum logic [13:0] {
      ST_CLEAR   = 14'b00000000000001,
      ST_IDLE    = 14'b00000000000010,
      ST_MOD     = 14'b00000000000100,
      ST_CHK     = 14'b00000000001000,
      ST_CMP     = 14'b00000000010000,
      ST_ALLOC   = 14'b00000000100000,
      ST_INS     = 14'b00000001000000,
      ST_SUM     = 14'b00000010000000,
      ST_DIV     = 14'b00000100000000,
      ST_SWHEAD  = 14'b00001000000000,
      ST_SWHCHK  = 14'b00010000000000,
      ST_SWENT   = 14'b00100000000000,
      ST_SWFREE  = 14'b01000000000000,
      ST_SPARE   = 14'b10000000000000
   } state_type;

endpackage

// ===== hw/rtl/chce_req_if.sv =====
// Lookup request channel: valid/ready with key, bucket and tag.
// Depends on chce_pkg.
interface chce_req_if
   import chce_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
);
   logic                valid;
   logic                ready;
   logic [KEY_BITS-1:0] position_key;
   logic [BUCKET_W-1:0] bucket_index;
   logic [TAG_BITS-1:0] game_tag;

   modport source (output valid, position_key, bucket_index, game_tag, input ready);
   modport sink   (input valid, position_key, bucket_index, game_tag, output ready);
endinterface

// ===== hw/rtl/chce_rsp_if.sv =====
// Lookup response channel: valid/ready with hit flag, slot and counts.
// Depends on chce_pkg.
interface chce_rsp_if
   import chce_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   was_hit;
   logic [SLOT_OUT_W-1:0]  entry_slot;
   logic [HITS_W-1:0]      entry_hits;
   logic [COUNT_OUT_W-1:0] evicted_count;
   logic [COUNT_OUT_W-1:0] stored_count;

   modport source (output valid, was_hit, entry_slot, entry_hits, evicted_count,
                   stored_count, input ready);
   modport sink   (input valid, was_hit, entry_slot, entry_hits, evicted_count,
                   stored_count, output ready);
endinterface

// ===== hw/rtl/chained_hash_cache_average_evict_unit.sv =====
// Chained hash cache with free list and average-based eviction sweep.
// Depends on chce_pkg, chce_req_if, chce_rsp_if and the macros header.
//
//  channel   | dir | handshake          | word
//  req_ch    | in  | valid/ready        | position_key, bucket_index, game_tag
//  rsp_ch    | out | valid/ready, reg'd | was_hit, entry_slot, entry_hits, counts
//
// A lookup folds the bucket into range, reads its chain head, then one chain entry per
// step (one entry-memory read each); a miss pushes a free-list slot onto the chain.
// A full pool triggers a sweep: sum the hits of every entry, divide by the stored count,
// then walk every chain, keeping and lowering entries above the average, freeing the rest.
// After reset the chain-head memory is cleared, with req held off.
// The result register waits on rsp_ch.ready; the block stalls only to deliver.
`include "chained_hash_cache_average_evict_unit_macros.svh"
module chained_hash_cache_average_evict_unit
   import chce_pkg::*;
#(
   parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
   parameter int CHAIN_SLOTS  = CHAIN_SLOTS_DEF,
   parameter int KEY_BITS     = KEY_BITS_DEF,
   parameter int TAG_BITS     = TAG_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   chce_req_if.sink   req_ch,
   chce_rsp_if.source rsp_ch
);

   localparam int SLOT_W = $clog2(POOL_ENTRIES);
   localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
   localparam int HEAD_W = $clog2(CHAIN_SLOTS);
   localparam int SUM_W  = HITS_W + LINK_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam logic [LINK_W-1:0] NIL       = LINK_W'(POOL_ENTRIES);
   localparam logic [HEAD_W-1:0] LAST_HEAD = HEAD_W'(CHAIN_SLOTS - 1);

   // memories
   logic [LINK_W-1:0]   head_mem [CHAIN_SLOTS];
   logic [KEY_BITS-1:0] key_mem  [POOL_ENTRIES];
   logic [TAG_BITS-1:0] tag_mem  [POOL_ENTRIES];
   logic [HITS_W-1:0]   hits_mem [POOL_ENTRIES];
   logic [LINK_W-1:0]   link_mem [POOL_ENTRIES];

   logic [LINK_W-1:0]   head_rd_ff;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [HITS_W-1:0]   hits_rd_ff;
   logic [LINK_W-1:0]   link_rd_ff;

   logic                head_re, head_we, ent_re, link_we, hits_we, key_we, tag_we;
   logic [HEAD_W-1:0]   head_ra, head_wa;
   logic [LINK_W-1:0]   head_wd, link_wd;
   logic [SLOT_W-1:0]   ent_ra, link_wa, hits_wa, ent_wa;
   logic [HITS_W-1:0]   hits_wd;

   // control and working registers
   state_type           state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [BUCKET_W-1:0] bkt_ff, bkt_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [LINK_W-1:0]   cur_ff, cur_in, prev_ff, prev_in, nxt_ff, nxt_in;
   logic [LINK_W-1:0]   free_ff, free_in, fresh_ff, fresh_in, count_ff, count_in;
   logic [LINK_W-1:0]   freed_ff, freed_in, idx_ff, idx_in;
   logic [HEAD_W-1:0]   sb_ff, sb_in;
   logic                pend_ff, pend_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [LINK_W-1:0]   rem_ff, rem_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [HITS_W-1:0]   avg_ff, avg_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [HITS_W-1:0]      rsp_hits_ff, rsp_hits_in;
   logic [COUNT_OUT_W-1:0] rsp_evict_ff, rsp_evict_in, rsp_stored_ff, rsp_stored_in;

   logic                out_free;
   logic [LINK_W:0]     trial;
   logic [LINK_W-1:0]   next_free;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign trial        = {rem_ff, sum_ff[SUM_W-1]};
   assign next_free    = (free_ff >= fresh_ff) ? free_ff + LINK_W'(1) : link_rd_ff;

   // next-state and memory control
   always_comb begin
      state_in = state_ff;
      key_in = key_ff; bkt_in = bkt_ff; tag_in = tag_ff;
      cur_in = cur_ff; prev_in = prev_ff; nxt_in = nxt_ff;
      free_in = free_ff; fresh_in = fresh_ff; count_in = count_ff;
      freed_in = freed_ff; idx_in = idx_ff; sb_in = sb_ff; pend_in = 1'b0;
      sum_in = sum_ff; rem_in = rem_ff; dcnt_in = dcnt_ff; avg_in = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in = rsp_hit_ff; rsp_slot_in = rsp_slot_ff; rsp_hits_in = rsp_hits_ff;
      rsp_evict_in = rsp_evict_ff; rsp_stored_in = rsp_stored_ff;
      head_re = 1'b0; head_ra = HEAD_W'(bkt_ff);
      head_we = 1'b0; head_wa = sb_ff; head_wd = NIL;
      ent_re = 1'b0; ent_ra = cur_ff[SLOT_W-1:0];
      link_we = 1'b0; link_wa = cur_ff[SLOT_W-1:0]; link_wd = free_ff;
      hits_we = 1'b0; hits_wa = cur_ff[SLOT_W-1:0]; hits_wd = '0;
      key_we = 1'b0; tag_we = 1'b0; ent_wa = cur_ff[SLOT_W-1:0];

      unique case (state_ff)
         // write null into every chain head
         ST_CLEAR: begin
            head_we = 1'b1;
            if (sb_ff == LAST_HEAD) begin
               sb_in = '0;
               state_in = ST_IDLE;
            end else begin
               sb_in = sb_ff + HEAD_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               key_in = req_ch.position_key;
               bkt_in = req_ch.bucket_index;
               tag_in = req_ch.game_tag;
               freed_in = '0;
               state_in = ST_MOD;
            end
         end
         // fold the bucket into range, then read its head
         ST_MOD: begin
            if (32'(bkt_ff) >= 32'(CHAIN_SLOTS)) begin
               bkt_in = bkt_ff - BUCKET_W'(CHAIN_SLOTS);
            end else begin
               head_re = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (head_rd_ff == NIL) begin
               state_in = (count_ff >= NIL) ? ST_SUM : ST_ALLOC;
               idx_in = '0; sum_in = '0;
            end else begin
               ent_re = 1'b1; ent_ra = head_rd_ff[SLOT_W-1:0];
               cur_in = head_rd_ff;
               state_in = ST_CMP;
            end
         end
         // compare the current entry: respond on a hit, else advance along the chain
         ST_CMP: begin
            if (key_rd_ff == key_ff) begin
               if (out_free) begin
                  hits_we = 1'b1;
                  hits_wd = (hits_rd_ff != HITS_MAX) ? hits_rd_ff + HITS_W'(1) : hits_rd_ff;
                  tag_we = 1'b1;
                  rsp_valid_in = 1'b1; rsp_hit_in = 1'b1;
                  rsp_slot_in = SLOT_OUT_W'(cur_ff); rsp_hits_in = hits_wd;
                  rsp_evict_in = '0; rsp_stored_in = COUNT_OUT_W'(count_ff);
                  state_in = ST_IDLE;
               end
            end else if (link_rd_ff == NIL) begin
               state_in = (count_ff >= NIL) ? ST_SUM : ST_ALLOC;
               idx_in = '0; sum_in = '0;
            end else begin
               ent_re = 1'b1; ent_ra = link_rd_ff[SLOT_W-1:0];
               cur_in = link_rd_ff;
            end
         end
         ST_ALLOC: begin
            head_re = 1'b1;
            ent_re = 1'b1; ent_ra = free_ff[SLOT_W-1:0];
            state_in = ST_INS;
         end
         // pop the free list, if not empty, and push the slot onto the bucket's chain
         ST_INS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1; rsp_hit_in = 1'b0;
               rsp_evict_in = COUNT_OUT_W'(freed_ff);
               state_in = ST_IDLE;
               if (free_ff == NIL) begin
                  rsp_slot_in = '0; rsp_hits_in = '0;
                  rsp_stored_in = COUNT_OUT_W'(count_ff);
               end else begin
                  link_we = 1'b1; link_wa = free_ff[SLOT_W-1:0]; link_wd = head_rd_ff;
                  head_we = 1'b1; head_wa = HEAD_W'(bkt_ff); head_wd = free_ff;
                  key_we = 1'b1; tag_we = 1'b1; ent_wa = free_ff[SLOT_W-1:0];
                  hits_we = 1'b1; hits_wa = free_ff[SLOT_W-1:0]; hits_wd = HITS_W'(1);
                  if (free_ff >= fresh_ff) fresh_in = next_free;
                  free_in = next_free;
                  count_in = count_ff + LINK_W'(1);
                  rsp_slot_in = SLOT_OUT_W'(free_ff); rsp_hits_in = HITS_W'(1);
                  rsp_stored_in = COUNT_OUT_W'(count_ff + LINK_W'(1));
               end
            end
         end
         // total the hit counts of the full pool
         ST_SUM: begin
            if (idx_ff != NIL) begin
               ent_re = 1'b1; ent_ra = idx_ff[SLOT_W-1:0];
               idx_in = idx_ff + LINK_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) sum_in = sum_ff + SUM_W'(hits_rd_ff);
            if (idx_ff == NIL && !pend_ff) begin
               rem_in = '0; dcnt_in = '0;
               state_in = ST_DIV;
            end
         end
         // restoring divide, one quotient bit a cycle
         ST_DIV: begin
            if (dcnt_ff == DCNT_W'(SUM_W)) begin
               avg_in = sum_ff[HITS_W-1:0];
               sb_in = '0;
               state_in = ST_SWHEAD;
            end else begin
               dcnt_in = dcnt_ff + DCNT_W'(1);
               if (trial >= {1'b0, count_ff}) begin
                  rem_in = trial[LINK_W-1:0] - count_ff;
                  sum_in = {sum_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_in = trial[LINK_W-1:0];
                  sum_in = {sum_ff[SUM_W-2:0], 1'b0};
               end
            end
         end
         ST_SWHEAD: begin
            head_re = 1'b1; head_ra = sb_ff;
            prev_in = NIL;
            state_in = ST_SWHCHK;
         end
         ST_SWHCHK: begin
            if (head_rd_ff == NIL) begin
               if (sb_ff == LAST_HEAD) state_in = ST_ALLOC;
               else begin
                  sb_in = sb_ff + HEAD_W'(1); state_in = ST_SWHEAD;
               end
            end else begin
               ent_re = 1'b1; ent_ra = head_rd_ff[SLOT_W-1:0];
               cur_in = head_rd_ff;
               state_in = ST_SWENT;
            end
         end
         // keep and lower, or unlink
         ST_SWENT: begin
            if (hits_rd_ff > avg_ff) begin
               hits_we = 1'b1; hits_wd = hits_rd_ff - avg_ff;
               prev_in = cur_ff;
               if (link_rd_ff == NIL) begin
                  if (sb_ff == LAST_HEAD) state_in = ST_ALLOC;
                  else begin
                     sb_in = sb_ff + HEAD_W'(1); state_in = ST_SWHEAD;
                  end
               end else begin
                  ent_re = 1'b1; ent_ra = link_rd_ff[SLOT_W-1:0];
                  cur_in = link_rd_ff;
               end
            end else begin
               if (prev_ff == NIL) begin
                  head_we = 1'b1; head_wa = sb_ff; head_wd = link_rd_ff;
               end else begin
                  link_we = 1'b1; link_wa = prev_ff[SLOT_W-1:0]; link_wd = link_rd_ff;
               end
               nxt_in = link_rd_ff;
               state_in = ST_SWFREE;
            end
         end
         // push the unlinked entry onto the free list
         ST_SWFREE: begin
            link_we = 1'b1; link_wd = free_ff;
            free_in = cur_ff;
            if (count_ff != '0) count_in = count_ff - LINK_W'(1);
            freed_in = freed_ff + LINK_W'(1);
            if (nxt_ff == NIL) begin
               if (sb_ff == LAST_HEAD) state_in = ST_ALLOC;
               else begin
                  sb_in = sb_ff + HEAD_W'(1); state_in = ST_SWHEAD;
               end
            end else begin
               ent_re = 1'b1; ent_ra = nxt_ff[SLOT_W-1:0];
               cur_in = nxt_ff;
               state_in = ST_SWENT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (head_re) head_rd_ff <= head_mem[head_ra];
      if (head_we) head_mem[head_wa] <= head_wd;
   end

   always_ff @(posedge clock) begin
      if (ent_re) begin
         key_rd_ff  <= key_mem[ent_ra];
         hits_rd_ff <= hits_mem[ent_ra];
         link_rd_ff <= link_mem[ent_ra];
      end
      if (link_we) link_mem[link_wa] <= link_wd;
      if (hits_we) hits_mem[hits_wa] <= hits_wd;
      if (key_we)  key_mem[ent_wa]   <= key_ff;
      if (tag_we)  tag_mem[ent_wa]   <= tag_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sb_ff <= '0;
         free_ff <= '0;
         fresh_ff <= '0;
         count_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sb_ff <= sb_in;
         free_ff <= free_in;
         fresh_ff <= fresh_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      key_ff <= key_in; bkt_ff <= bkt_in; tag_ff <= tag_in;
      cur_ff <= cur_in; prev_ff <= prev_in; nxt_ff <= nxt_in;
      freed_ff <= freed_in; idx_ff <= idx_in;
      sum_ff <= sum_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in; avg_ff <= avg_in;
      rsp_hit_ff <= rsp_hit_in; rsp_slot_ff <= rsp_slot_in; rsp_hits_ff <= rsp_hits_in;
      rsp_evict_ff <= rsp_evict_in; rsp_stored_ff <= rsp_stored_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.was_hit       = rsp_hit_ff;
   assign rsp_ch.entry_slot    = rsp_slot_ff;
   assign rsp_ch.entry_hits    = rsp_hits_ff;
   assign rsp_ch.evicted_count = rsp_evict_ff;
   assign rsp_ch.stored_count  = rsp_stored_ff;

   // checks
   `CHCE_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= NIL)
   `CHCE_ASSERT_IMPL(a_alloc_room, clock, reset, state_ff == ST_ALLOC, count_ff < NIL)
   `CHCE_ASSERT_IMPL(a_fresh_tail, clock, reset, free_ff >= fresh_ff,
                     free_ff == fresh_ff || free_ff == NIL)
   `CHCE_ASSERT_NEXT(a_rsp_from_work, clock, reset,
                     state_ff == ST_IDLE && !(rsp_valid_ff && !rsp_ch.ready),
                     !rsp_valid_ff)

endmodule
